// ===== src/hsv2rgb_pkg.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter package
// Field layout, fixed-point formats, sector codes and shared helpers.
// ----------------------------------------------------------------------------
package hsv2rgb_pkg;

  // Input and output field widths.
  localparam int HUE_W    = 15;
  localparam int LVL_IN_W = 17;
  localparam int BYTE_W   = 8;

  // Fixed-point formats.
  localparam int HUE_FRAC_BITS   = 6;
  localparam int LEVEL_FRAC_BITS = 16;
  localparam int LW              = LEVEL_FRAC_BITS + 1;
  localparam logic [LW-1:0] LVL_ONE = {1'b1, {LEVEL_FRAC_BITS{1'b0}}};

  // One 60-degree sector and the full circle, in hue units.
  localparam int HUE_SEG  = 60 << HUE_FRAC_BITS;
  localparam int HUE_FULL = 360 << HUE_FRAC_BITS;
  localparam int REM_W    = $clog2(HUE_SEG);

  // Highest sector number that a hue field can reach.
  localparam int SECT_MAX = ((1 << HUE_W) - 1) / HUE_SEG;
  localparam int SECT_W   = $clog2(SECT_MAX + 1);

  // The fraction rem * ONE / HUE_SEG is taken as (rem * RECIP) >> FRAC_SH.
  // RECIP is rounded up, and 2^(FRAC_SH + LEVEL_FRAC_BITS) exceeds the
  // largest numerator times HUE_SEG, so the quotient is exact.
  localparam int FRAC_SH = 2 * REM_W;
  localparam int RECIP_W = FRAC_SH + LEVEL_FRAC_BITS - REM_W + 1;
  localparam logic [63:0] RECIP_FULL =
    ((64'd1 << (FRAC_SH + LEVEL_FRAC_BITS)) + 64'(HUE_SEG) - 64'd1) / 64'(HUE_SEG);
  localparam logic [RECIP_W-1:0] RECIP = RECIP_FULL[RECIP_W-1:0];

  // Sector codes. Every code above the magenta sector uses the last mapping.
  localparam logic [SECT_W-1:0] SEC_RED_YEL = SECT_W'(0);
  localparam logic [SECT_W-1:0] SEC_YEL_GRN = SECT_W'(1);
  localparam logic [SECT_W-1:0] SEC_GRN_CYN = SECT_W'(2);
  localparam logic [SECT_W-1:0] SEC_CYN_BLU = SECT_W'(3);
  localparam logic [SECT_W-1:0] SEC_BLU_MAG = SECT_W'(4);

  // Stream payload layout.
  localparam int HUE_LSB    = 0;
  localparam int SAT_LSB    = HUE_LSB + HUE_W;
  localparam int VAL_LSB    = SAT_LSB + LVL_IN_W;
  localparam int OPA_LSB    = VAL_LSB + LVL_IN_W;
  localparam int IN_FIELDS  = OPA_LSB + LVL_IN_W;
  localparam int IN_DATA_W  = ((IN_FIELDS + 7) / 8) * 8;
  localparam int OUT_DATA_W = 4 * BYTE_W;

  localparam int QUEUE_DEPTH = 4;

  // One classified item as it travels from the front end to the back end.
  typedef struct packed {
    logic              grey;
    logic [SECT_W-1:0] sector;
    logic [REM_W-1:0]  rem;
    logic [LW-1:0]     sat;
    logic [LW-1:0]     val;
    logic [BYTE_W-1:0] opa_byte;
  } item_t;

  // Levels above one are pinned to one.
  function automatic logic [LW-1:0] clamp_level(input logic [LVL_IN_W-1:0] x);
    if (32'(x) > 32'(LVL_ONE)) begin
      return LVL_ONE;
    end
    return LW'(x);
  endfunction

  // (level * 255) >> LEVEL_FRAC_BITS, done as a shift and a subtract.
  function automatic logic [BYTE_W-1:0] to_byte(input logic [LW-1:0] lvl);
    logic [LW+BYTE_W-1:0] prod;
    prod = {lvl, {BYTE_W{1'b0}}} - {{BYTE_W{1'b0}}, lvl};
    return prod[LEVEL_FRAC_BITS +: BYTE_W];
  endfunction

endpackage

// ===== src/hsv2rgb_front.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB front end
// Unpacks an item, clamps the levels, splits the hue into sector and remainder.
// ----------------------------------------------------------------------------
module hsv2rgb_front (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [hsv2rgb_pkg::IN_DATA_W-1:0]  in_data,
  output logic                               out_valid,
  input  logic                               out_ready,
  output hsv2rgb_pkg::item_t                 out_item
);

  logic [hsv2rgb_pkg::HUE_W-1:0]    hue;
  logic [hsv2rgb_pkg::HUE_W-1:0]    hue_eff;
  logic [hsv2rgb_pkg::HUE_W-1:0]    base;
  logic [hsv2rgb_pkg::SECT_W-1:0]   sector;
  logic [hsv2rgb_pkg::LW-1:0]       sat;
  logic [hsv2rgb_pkg::LW-1:0]       val;
  logic [hsv2rgb_pkg::LW-1:0]       opa;
  hsv2rgb_pkg::item_t               item_next;
  hsv2rgb_pkg::item_t               item_reg;
  logic                             valid;
  logic                             accept;

  assign hue = in_data[hsv2rgb_pkg::HUE_LSB +: hsv2rgb_pkg::HUE_W];
  assign sat = hsv2rgb_pkg::clamp_level(
                 in_data[hsv2rgb_pkg::SAT_LSB +: hsv2rgb_pkg::LVL_IN_W]);
  assign val = hsv2rgb_pkg::clamp_level(
                 in_data[hsv2rgb_pkg::VAL_LSB +: hsv2rgb_pkg::LVL_IN_W]);
  assign opa = hsv2rgb_pkg::clamp_level(
                 in_data[hsv2rgb_pkg::OPA_LSB +: hsv2rgb_pkg::LVL_IN_W]);

  // A hue of a full turn is the same as zero.
  assign hue_eff = (hue == hsv2rgb_pkg::HUE_W'(hsv2rgb_pkg::HUE_FULL)) ? '0 : hue;

  // Sector number by comparing against every sector boundary.
  always_comb begin
    sector = '0;
    base   = '0;
    for (int k = 1; k <= hsv2rgb_pkg::SECT_MAX; k++) begin
      if (int'(hue_eff) >= k * hsv2rgb_pkg::HUE_SEG) begin
        sector = hsv2rgb_pkg::SECT_W'(k);
        base   = hsv2rgb_pkg::HUE_W'(k * hsv2rgb_pkg::HUE_SEG);
      end
    end
  end

  always_comb begin
    item_next.grey     = (sat == '0);
    item_next.sector   = sector;
    item_next.rem      = hsv2rgb_pkg::REM_W'(hue_eff - base);
    item_next.sat      = sat;
    item_next.val      = val;
    item_next.opa_byte = hsv2rgb_pkg::to_byte(opa);
  end

  assign in_ready  = !valid || out_ready;
  assign accept    = in_valid && in_ready;
  assign out_valid = valid;
  assign out_item  = item_reg;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (accept) begin
      valid <= 1'b1;
    end else if (out_ready) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item_reg <= item_next;
    end
  end

endmodule

// ===== src/hsv2rgb_queue.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB item queue
// Small register queue that lets the front and back ends stall on their own.
// ----------------------------------------------------------------------------
module hsv2rgb_queue (
  input  logic               clk,
  input  logic               rst,
  input  logic               push_valid,
  output logic               push_ready,
  input  hsv2rgb_pkg::item_t push_item,
  output logic               pop_valid,
  input  logic               pop_ready,
  output hsv2rgb_pkg::item_t pop_item
);

  localparam int DEPTH = hsv2rgb_pkg::QUEUE_DEPTH;
  localparam int PTR_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);

  hsv2rgb_pkg::item_t entries [DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;
  logic               push;
  logic               pop;

  assign push_ready = (count != CNT_W'(DEPTH));
  assign pop_valid  = (count != '0);
  assign push       = push_valid && push_ready;
  assign pop        = pop_valid && pop_ready;
  assign pop_item   = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_item;
    end
  end

  a_count_up: assert property (@(posedge clk) disable iff (rst)
    push && !pop |=> count == $past(count) + 1'b1)
    else $error("queue count did not rise on a lone push");

  a_count_down: assert property (@(posedge clk) disable iff (rst)
    pop && !push |=> count == $past(count) - 1'b1)
    else $error("queue count did not fall on a lone pop");

  a_count_hold: assert property (@(posedge clk) disable iff (rst)
    push && pop |=> count == $past(count) && rd_ptr != $past(rd_ptr))
    else $error("queue count or read pointer wrong on push with pop");

endmodule

// ===== src/hsv2rgb_back.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB back end
// Pipelined arithmetic: hue fraction, p/q/t levels, sector mapping, bytes.
// ----------------------------------------------------------------------------
module hsv2rgb_back (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  hsv2rgb_pkg::item_t                  in_item,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [hsv2rgb_pkg::OUT_DATA_W-1:0]  out_data
);

  localparam int LW   = hsv2rgb_pkg::LW;
  localparam int LFB  = hsv2rgb_pkg::LEVEL_FRAC_BITS;
  localparam int FP_W = hsv2rgb_pkg::REM_W + hsv2rgb_pkg::RECIP_W;
  localparam int BW   = hsv2rgb_pkg::BYTE_W;
  localparam int SW   = hsv2rgb_pkg::SECT_W;

  logic en;

  // Stage 1: fraction within the sector.
  logic [FP_W-1:0] f_prod;
  logic            v1;
  logic            s1_grey;
  logic [SW-1:0]   s1_sec;
  logic [LW-1:0]   s1_sat;
  logic [LW-1:0]   s1_val;
  logic [BW-1:0]   s1_abyte;
  logic [LFB-1:0]  s1_f;

  // Stage 2: saturation scaled by f and by one minus f.
  logic [LW-1:0]   omf;
  logic [2*LW-1:0] sq_prod;
  logic [2*LW-1:0] st_prod;
  logic            v2;
  logic            s2_grey;
  logic [SW-1:0]   s2_sec;
  logic [LW-1:0]   s2_sat;
  logic [LW-1:0]   s2_val;
  logic [BW-1:0]   s2_abyte;
  logic [LW-1:0]   s2_sq;
  logic [LW-1:0]   s2_st;

  // Stage 3: the p, q and t levels.
  logic [2*LW-1:0] p_prod;
  logic [2*LW-1:0] q_prod;
  logic [2*LW-1:0] t_prod;
  logic            v3;
  logic            s3_grey;
  logic [SW-1:0]   s3_sec;
  logic [LW-1:0]   s3_val;
  logic [BW-1:0]   s3_abyte;
  logic [LW-1:0]   s3_p;
  logic [LW-1:0]   s3_q;
  logic [LW-1:0]   s3_t;

  // Stage 4: channel mapping and the output register.
  logic [LW-1:0]   lvl_r;
  logic [LW-1:0]   lvl_g;
  logic [LW-1:0]   lvl_b;
  logic            valid_out;
  logic [BW-1:0]   red;
  logic [BW-1:0]   green;
  logic [BW-1:0]   blue;
  logic [BW-1:0]   alpha;

  // The whole pipeline advances together whenever the output slot frees up.
  assign en       = !valid_out || out_ready;
  assign in_ready = en;

  assign f_prod = FP_W'(in_item.rem) * FP_W'(hsv2rgb_pkg::RECIP);

  always_ff @(posedge clk) begin
    if (en) begin
      s1_grey  <= in_item.grey;
      s1_sec   <= in_item.sector;
      s1_sat   <= in_item.sat;
      s1_val   <= in_item.val;
      s1_abyte <= in_item.opa_byte;
      s1_f     <= f_prod[hsv2rgb_pkg::FRAC_SH +: LFB];
    end
  end

  assign omf     = hsv2rgb_pkg::LVL_ONE - {1'b0, s1_f};
  assign sq_prod = (2*LW)'(s1_sat) * (2*LW)'({1'b0, s1_f});
  assign st_prod = (2*LW)'(s1_sat) * (2*LW)'(omf);

  always_ff @(posedge clk) begin
    if (en) begin
      s2_grey  <= s1_grey;
      s2_sec   <= s1_sec;
      s2_sat   <= s1_sat;
      s2_val   <= s1_val;
      s2_abyte <= s1_abyte;
      s2_sq    <= sq_prod[LFB +: LW];
      s2_st    <= st_prod[LFB +: LW];
    end
  end

  assign p_prod = (2*LW)'(s2_val) * (2*LW)'(hsv2rgb_pkg::LVL_ONE - s2_sat);
  assign q_prod = (2*LW)'(s2_val) * (2*LW)'(hsv2rgb_pkg::LVL_ONE - s2_sq);
  assign t_prod = (2*LW)'(s2_val) * (2*LW)'(hsv2rgb_pkg::LVL_ONE - s2_st);

  always_ff @(posedge clk) begin
    if (en) begin
      s3_grey  <= s2_grey;
      s3_sec   <= s2_sec;
      s3_val   <= s2_val;
      s3_abyte <= s2_abyte;
      s3_p     <= p_prod[LFB +: LW];
      s3_q     <= q_prod[LFB +: LW];
      s3_t     <= t_prod[LFB +: LW];
    end
  end

  always_comb begin
    if (s3_grey) begin
      lvl_r = s3_val;
      lvl_g = s3_val;
      lvl_b = s3_val;
    end else begin
      unique case (s3_sec)
        hsv2rgb_pkg::SEC_RED_YEL: begin
          lvl_r = s3_val; lvl_g = s3_t;   lvl_b = s3_p;
        end
        hsv2rgb_pkg::SEC_YEL_GRN: begin
          lvl_r = s3_q;   lvl_g = s3_val; lvl_b = s3_p;
        end
        hsv2rgb_pkg::SEC_GRN_CYN: begin
          lvl_r = s3_p;   lvl_g = s3_val; lvl_b = s3_t;
        end
        hsv2rgb_pkg::SEC_CYN_BLU: begin
          lvl_r = s3_p;   lvl_g = s3_q;   lvl_b = s3_val;
        end
        hsv2rgb_pkg::SEC_BLU_MAG: begin
          lvl_r = s3_t;   lvl_g = s3_p;   lvl_b = s3_val;
        end
        default: begin
          lvl_r = s3_val; lvl_g = s3_p;   lvl_b = s3_q;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red   <= hsv2rgb_pkg::to_byte(lvl_r);
      green <= hsv2rgb_pkg::to_byte(lvl_g);
      blue  <= hsv2rgb_pkg::to_byte(lvl_b);
      alpha <= s3_abyte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      v1        <= 1'b0;
      v2        <= 1'b0;
      v3        <= 1'b0;
      valid_out <= 1'b0;
    end else if (en) begin
      v1        <= in_valid;
      v2        <= v1;
      v3        <= v2;
      valid_out <= v3;
    end
  end

  assign out_valid = valid_out;
  assign out_data  = {alpha, blue, green, red};

  a_advance: assert property (@(posedge clk) disable iff (rst)
    v3 && en |=> valid_out)
    else $error("item in the last stage was not moved to the output");

  a_grey: assert property (@(posedge clk) disable iff (rst)
    v3 && en && s3_grey |=> red == green && green == blue)
    else $error("grey item gave unequal channels");

  a_sector0: assert property (@(posedge clk) disable iff (rst)
    v3 && en && !s3_grey && s3_sec == hsv2rgb_pkg::SEC_RED_YEL
      |=> red >= green && green >= blue)
    else $error("red-yellow sector gave channels out of order");

endmodule

// ===== src/hsv_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter
// Path: an item passes the front-end register and the queue, then the back end.
// Throughput: one item per cycle, set by the four-stage arithmetic pipeline in
// the back end, which advances whenever its output register is free.
// Reset: synchronous, clears all valid flags and the queue; no result is
// pending after reset and payload registers keep whatever they hold.
// ----------------------------------------------------------------------------
//
// Each item carries one color as hue, saturation, value and opacity, and
// yields one 8-bit RGBA result. The front end clamps the levels to one,
// folds a hue of a full turn to zero and splits the hue into a 60-degree
// sector number and a remainder. Classified items go through a short queue
// to the back end, which forms the fraction within the sector, the p, q and
// t levels, maps them onto the channels by sector and scales every channel
// by 255 with truncation. Zero saturation gives grey at the value level.
//
// The queue lets the front end keep taking items while the output side is
// stalled, until its four entries are full, and the output register keeps a
// finished result while new items continue to enter.

module hsv_to_rgb_converter (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // hue[14:0], saturation[31:15], brightness[48:32], opacity[65:49], zero fill
  input  logic [hsv2rgb_pkg::IN_DATA_W-1:0]   s_axis_tdata,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // red[7:0], green[15:8], blue[23:16], alpha[31:24]
  output logic [hsv2rgb_pkg::OUT_DATA_W-1:0]  m_axis_tdata
);

  hsv2rgb_pkg::item_t front_item;
  hsv2rgb_pkg::item_t queue_item;
  logic               front_valid;
  logic               queue_ready;
  logic               queue_valid;
  logic               back_ready;

  // Front end: unpacking, level clamping and hue classification.
  hsv2rgb_front u_front (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (s_axis_tvalid),
    .in_ready  (s_axis_tready),
    .in_data   (s_axis_tdata),
    .out_valid (front_valid),
    .out_ready (queue_ready),
    .out_item  (front_item)
  );

  // Queue between the two halves.
  hsv2rgb_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (front_valid),
    .push_ready (queue_ready),
    .push_item  (front_item),
    .pop_valid  (queue_valid),
    .pop_ready  (back_ready),
    .pop_item   (queue_item)
  );

  // Back end: multiply pipeline, channel mapping and output register.
  hsv2rgb_back u_back (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (queue_valid),
    .in_ready  (back_ready),
    .in_item   (queue_item),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_data  (m_axis_tdata)
  );

endmodule

// ===== tb/hsv_to_rgb_converter_tb.sv =====
// ----------------------------------------------------------------------------
// HSV to RGB converter testbench
// Streams colors into the converter with random gaps and output stalls.
// A fixed-point predictor in the bench works out the expected RGBA bytes for
// every accepted item, and each result is checked against them in order.
// ----------------------------------------------------------------------------
module hsv_to_rgb_converter_tb;

  // Field widths and fixed-point formats shared with the design.
  localparam int HUE_W           = hsv2rgb_pkg::HUE_W;
  localparam int LVL_IN_W        = hsv2rgb_pkg::LVL_IN_W;
  localparam int BYTE_W          = hsv2rgb_pkg::BYTE_W;
  localparam int LEVEL_FRAC_BITS = hsv2rgb_pkg::LEVEL_FRAC_BITS;
  localparam int HUE_SEG         = hsv2rgb_pkg::HUE_SEG;
  localparam int HUE_FULL        = hsv2rgb_pkg::HUE_FULL;
  localparam int IN_DATA_W       = hsv2rgb_pkg::IN_DATA_W;
  localparam int OUT_DATA_W      = hsv2rgb_pkg::OUT_DATA_W;
  localparam logic [hsv2rgb_pkg::LW-1:0] LVL_ONE = hsv2rgb_pkg::LVL_ONE;

  // The run is ended by force once this many cycles have passed.
  localparam int CYCLE_LIMIT = 600000;
  // Extra cycles to watch for stray results once nothing is pending.
  localparam int DRAIN_CYCLES = 20;
  localparam int RANDOM_CHUNK = 357;

  // Hue of one full sector and a full turn, as 15-bit field values.
  localparam logic [HUE_W-1:0] SECTOR_SPAN = HUE_W'(HUE_SEG);
  localparam logic [HUE_W-1:0] FULL_TURN   = HUE_W'(HUE_FULL);
  localparam logic [LVL_IN_W-1:0] UNITY    = LVL_IN_W'(LVL_ONE);

  typedef struct packed {
    logic [BYTE_W-1:0] alpha;
    logic [BYTE_W-1:0] blue;
    logic [BYTE_W-1:0] green;
    logic [BYTE_W-1:0] red;
  } rgba_t;

  logic                  clk;
  logic                  rst;
  logic                  s_axis_tvalid;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Colors expected from the converter, oldest first.
  rgba_t pending_rgba[$];
  int    mismatches = 0;
  int    cycle_count = 0;
  // When set, the matching side of the stream never idles.
  bit    send_calm;
  bit    drain_calm;

  hsv_to_rgb_converter u_top (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // ---------------------------------------------------------------------------
  // Predictor. All arithmetic is done in 64 bits, with every shift truncating,
  // so the intermediate products of the fixed-point format never overflow.
  // ---------------------------------------------------------------------------

  // Saturation, value and opacity above one are pinned to one.
  function automatic logic [63:0] pin_level(input logic [LVL_IN_W-1:0] raw);
    if (64'(raw) > 64'(LVL_ONE)) begin
      return 64'(LVL_ONE);
    end
    return 64'(raw);
  endfunction

  function automatic logic [BYTE_W-1:0] level_to_byte(input logic [63:0] lvl);
    logic [63:0] scaled;
    scaled = (lvl * 64'd255) >> LEVEL_FRAC_BITS;
    return scaled[BYTE_W-1:0];
  endfunction

  // Value darkened by the saturation scaled with a fraction k in [0, one].
  function automatic logic [63:0] shade_level(input logic [63:0] v, input logic [63:0] s,
                                              input logic [63:0] k);
    logic [63:0] dim;
    dim = (s * k) >> LEVEL_FRAC_BITS;
    return (v * (64'(LVL_ONE) - dim)) >> LEVEL_FRAC_BITS;
  endfunction

  function automatic rgba_t predict_rgba(input logic [HUE_W-1:0] hue,
                                         input logic [LVL_IN_W-1:0] sat_raw,
                                         input logic [LVL_IN_W-1:0] val_raw,
                                         input logic [LVL_IN_W-1:0] opa_raw);
    logic [63:0] h, s, v, one, sector, rem, frac, p, q, t, r, g, b;
    rgba_t res;
    one = 64'(LVL_ONE);
    h   = 64'(hue);
    s   = pin_level(sat_raw);
    v   = pin_level(val_raw);
    if (s == 64'd0) begin
      // No saturation: a grey at the value level whatever the hue.
      r = v;
      g = v;
      b = v;
    end else begin
      // A full turn folds back onto the start of the red sector.
      if (h == 64'(HUE_FULL)) begin
        h = 64'd0;
      end
      sector = h / 64'(HUE_SEG);
      rem    = h % 64'(HUE_SEG);
      frac   = (rem * one) / 64'(HUE_SEG);
      p = shade_level(v, s, one);
      q = shade_level(v, s, frac);
      t = shade_level(v, s, one - frac);
      // Hues past a full turn land in sector six or higher and share the
      // magenta-to-red mapping of sector five.
      case (sector)
        64'(hsv2rgb_pkg::SEC_RED_YEL): begin r = v; g = t; b = p; end
        64'(hsv2rgb_pkg::SEC_YEL_GRN): begin r = q; g = v; b = p; end
        64'(hsv2rgb_pkg::SEC_GRN_CYN): begin r = p; g = v; b = t; end
        64'(hsv2rgb_pkg::SEC_CYN_BLU): begin r = p; g = q; b = v; end
        64'(hsv2rgb_pkg::SEC_BLU_MAG): begin r = t; g = p; b = v; end
        default: begin r = v; g = p; b = q; end
      endcase
    end
    res.red   = level_to_byte(r);
    res.green = level_to_byte(g);
    res.blue  = level_to_byte(b);
    res.alpha = level_to_byte(pin_level(opa_raw));
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Idle lengths: mostly none or short, now and then a long pause.
  // ---------------------------------------------------------------------------
  function automatic int pick_gap(input bit calm);
    int roll;
    if (calm) begin
      return 0;
    end
    roll = $urandom_range(0, 99);
    if (roll < 55) begin
      return 0;
    end else if (roll < 90) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(4, 40);
  endfunction

  // ---------------------------------------------------------------------------
  // Result checking. Results are compared before the item accepted in the same
  // cycle is predicted, so the queue order is fixed within the time step.
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    rgba_t want;
    rgba_t got;
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        got = rgba_t'(m_axis_tdata);
        if (pending_rgba.size() == 0) begin
          if (mismatches < 10) begin
            $display("unexpected result r=%0d g=%0d b=%0d a=%0d",
                     got.red, got.green, got.blue, got.alpha);
          end
          mismatches++;
        end else begin
          want = pending_rgba.pop_front();
          if (got.red != want.red || got.green != want.green ||
              got.blue != want.blue || got.alpha != want.alpha) begin
            if (mismatches < 10) begin
              $display({"color mismatch: expected r=%0d g=%0d b=%0d a=%0d,",
                        " got r=%0d g=%0d b=%0d a=%0d"},
                       want.red, want.green, want.blue, want.alpha,
                       got.red, got.green, got.blue, got.alpha);
            end
            mismatches++;
          end
        end
      end
      if (s_axis_tvalid && s_axis_tready) begin
        pending_rgba.push_back(
          predict_rgba(s_axis_tdata[hsv2rgb_pkg::HUE_LSB +: HUE_W],
                       s_axis_tdata[hsv2rgb_pkg::SAT_LSB +: LVL_IN_W],
                       s_axis_tdata[hsv2rgb_pkg::VAL_LSB +: LVL_IN_W],
                       s_axis_tdata[hsv2rgb_pkg::OPA_LSB +: LVL_IN_W]));
      end
    end
  end

  // Watchdog: a hung handshake ends the run as a failure.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // Output side: ready stays high between stalls of random length.
  initial begin
    int stall;
    m_axis_tready = 1'b0;
    stall = 0;
    forever begin
      @(negedge clk);
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        stall--;
      end else begin
        m_axis_tready <= 1'b1;
        stall = pick_gap(drain_calm);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus.
  // ---------------------------------------------------------------------------

  // Sends one item. During the idle gap, tdata carries junk with tvalid low so
  // that the converter is seen to ignore it. Valid stays high from one item to
  // the next when there is no gap.
  task automatic send_hsv(input logic [HUE_W-1:0] hue, input logic [LVL_IN_W-1:0] sat,
                          input logic [LVL_IN_W-1:0] val, input logic [LVL_IN_W-1:0] opa);
    int gap;
    gap = pick_gap(send_calm);
    repeat (gap) begin
      @(negedge clk);
      s_axis_tvalid <= 1'b0;
      s_axis_tdata  <= IN_DATA_W'({$urandom, $urandom, $urandom});
    end
    @(negedge clk);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= IN_DATA_W'({opa, val, sat, hue});
    do begin
      @(posedge clk);
    end while (!s_axis_tready);
  endtask

  // Random level: zero, exactly one, above one, or anywhere in between.
  function automatic logic [LVL_IN_W-1:0] random_level();
    int roll;
    roll = $urandom_range(0, 99);
    if (roll < 12) begin
      return '0;
    end else if (roll < 22) begin
      return UNITY;
    end else if (roll < 35) begin
      return LVL_IN_W'($urandom_range(32'(LVL_ONE) + 1, (1 << LVL_IN_W) - 1));
    end
    return LVL_IN_W'($urandom_range(0, 32'(LVL_ONE)));
  endfunction

  // Random hue: mostly a real angle, some near sector edges, some anywhere in the field.
  function automatic logic [HUE_W-1:0] random_hue();
    int roll;
    int edge_idx;
    roll = $urandom_range(0, 99);
    if (roll < 70) begin
      return HUE_W'($urandom_range(0, HUE_FULL));
    end else if (roll < 82) begin
      edge_idx = $urandom_range(0, 6);
      return HUE_W'(edge_idx * HUE_SEG + $urandom_range(0, 2) - 1);
    end
    return HUE_W'($urandom_range(0, (1 << HUE_W) - 1));
  endfunction

  // Grey colors: zero saturation at several hues and levels.
  task automatic test_grey();
    send_hsv('0, '0, UNITY, UNITY);
    send_hsv(HUE_W'(12345), '0, LVL_IN_W'(32768), '0);
    send_hsv(FULL_TURN, '0, '0, UNITY);
  endtask

  // Hues at both sides of every sector edge, a full turn and beyond it.
  task automatic test_sectors();
    send_hsv('0, UNITY, UNITY, UNITY);
    send_hsv(FULL_TURN, UNITY, UNITY, UNITY);
    for (int k = 1; k <= 6; k++) begin
      send_hsv(HUE_W'(k) * SECTOR_SPAN - 1'b1, UNITY, UNITY, UNITY);
      if (k < 6) begin
        send_hsv(HUE_W'(k) * SECTOR_SPAN, UNITY, UNITY, UNITY);
      end
    end
    send_hsv(FULL_TURN + 1'b1, LVL_IN_W'(40000), LVL_IN_W'(50000), LVL_IN_W'(30000));
    send_hsv('1, LVL_IN_W'(40000), LVL_IN_W'(50000), LVL_IN_W'(30000));
  endtask

  // Levels at and above one, and a black color.
  task automatic test_level_extremes();
    send_hsv(HUE_W'(1000), '1, '1, '1);
    send_hsv(HUE_W'(20000), UNITY + 1'b1, LVL_IN_W'(100000), LVL_IN_W'(98304));
    send_hsv(HUE_W'(5000), UNITY, '0, LVL_IN_W'(1));
  endtask

  // Random colors in phases: both sides idling, only the output side, only the input side, neither.
  task automatic test_random_colors();
    for (int phase = 0; phase < 4; phase++) begin
      send_calm  = (phase == 1) || (phase == 3);
      drain_calm = (phase == 2) || (phase == 3);
      repeat (RANDOM_CHUNK) begin
        send_hsv(random_hue(), random_level(), random_level(), random_level());
      end
    end
    send_calm  = 1'b0;
    drain_calm = 1'b0;
  endtask

  initial begin
    rst           = 1'b1;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    send_calm     = 1'b0;
    drain_calm    = 1'b0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_grey();
    test_sectors();
    test_level_extremes();
    test_random_colors();

    @(negedge clk);
    s_axis_tvalid <= 1'b0;
    while (pending_rgba.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
